>>> rtl/bse_pkg.sv
// Shared types and codes for the bucket sort engine.
// No dependencies; imported by bse_sorter, bucket_sort_engine_core and the testbench.
package bse_pkg;

    localparam int MAX_ITEMS_DEF = 1024;
    localparam int KEY_BITS      = 16;
    localparam int STATUS_BITS   = 2;

    // Operation codes carried on op
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OVFL  = 2'd2;

endpackage

>>> rtl/bse_sorter.sv
// Key store, sorted store, bucket fill memory and the bucket sort sequencer.
// Depends on bse_pkg.
module bse_sorter #(
    parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF,
    parameter int CW = $clog2(MAX_ITEMS + 1),
    parameter int AW = $clog2(MAX_ITEMS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [CW-1:0]                 n,
    output logic                          busy,
    output logic                          done,
    input  logic                          ld_we,
    input  logic [AW-1:0]                 ld_addr,
    input  logic [bse_pkg::KEY_BITS-1:0]  ld_key,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [bse_pkg::KEY_BITS-1:0]  rd_data
);
    import bse_pkg::*;

    localparam int PW = CW + KEY_BITS;

    typedef enum logic [18:0] {
        S_IDLE = 19'b0000000000000000001,
        S_CLR  = 19'b0000000000000000010,
        S_CRD  = 19'b0000000000000000100,
        S_CMUL = 19'b0000000000000001000,
        S_CFRD = 19'b0000000000000010000,
        S_CFWR = 19'b0000000000000100000,
        S_PRD  = 19'b0000000000001000000,
        S_PWR  = 19'b0000000000010000000,
        S_SRD  = 19'b0000000000100000000,
        S_SMUL = 19'b0000000001000000000,
        S_SFRD = 19'b0000000010000000000,
        S_SFWR = 19'b0000000100000000000,
        S_BRD  = 19'b0000001000000000000,
        S_BGET = 19'b0000010000000000000,
        S_JCHK = 19'b0000100000000000000,
        S_JV   = 19'b0001000000000000000,
        S_PCHK = 19'b0010000000000000000,
        S_PCMP = 19'b0100000000000000000,
        S_DONE = 19'b1000000000000000000
    } sort_state_t;

    // Memories
    logic [KEY_BITS-1:0] key_mem [MAX_ITEMS];
    logic [KEY_BITS-1:0] srt_mem [MAX_ITEMS];
    logic [CW-1:0]       fill_mem [MAX_ITEMS];

    logic [KEY_BITS-1:0] key_q;
    logic [KEY_BITS-1:0] srt_q;
    logic [CW-1:0]       fill_q;

    logic                key_re;
    logic                fill_we, fill_re, srt_we, srt_re;
    logic [AW-1:0]       fill_waddr, fill_raddr, srt_waddr, srt_raddr, key_raddr;
    logic [CW-1:0]       fill_wdata;
    logic [KEY_BITS-1:0] srt_wdata;

    sort_state_t         state_reg, state_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       start_reg, start_next;
    logic [CW-1:0]       end_reg, end_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [CW-1:0]       p_reg, p_next;
    logic [AW-1:0]       b_reg, b_next;
    logic [KEY_BITS-1:0] v_reg, v_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic                last;
    logic [AW-1:0]       bucket;
    logic [CW-1:0]       p_dec;

    assign last    = (i_reg == n_reg - CW'(1));
    assign bucket  = prod_reg[KEY_BITS +: AW];
    assign p_dec   = p_reg - CW'(1);
    assign busy    = (state_reg != S_IDLE);
    assign rd_data = srt_q;

    // Key store: written by loads, read by the count and scatter passes
    always_ff @(posedge clk)
    begin
        if (ld_we)
        begin
            key_mem[ld_addr] <= ld_key;
        end
        if (key_re)
        begin
            key_q <= key_mem[key_raddr];
        end
    end

    // Bucket fill memory
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        if (fill_re)
        begin
            fill_q <= fill_mem[fill_raddr];
        end
    end

    // Sorted store
    always_ff @(posedge clk)
    begin
        if (srt_we)
        begin
            srt_mem[srt_waddr] <= srt_wdata;
        end
        if (srt_re)
        begin
            srt_q <= srt_mem[srt_raddr];
        end
    end

    // Sequencer: clear, count, prefix, scatter, per-bucket insertion sort
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        start_next = start_reg;
        end_next   = end_reg;
        j_next     = j_reg;
        p_next     = p_reg;
        b_next     = b_reg;
        v_next     = v_reg;
        prod_next  = prod_reg;
        done       = 1'b0;
        key_re     = 1'b0;
        key_raddr  = i_reg[AW-1:0];
        fill_we    = 1'b0;
        fill_waddr = i_reg[AW-1:0];
        fill_wdata = '0;
        fill_re    = 1'b0;
        fill_raddr = i_reg[AW-1:0];
        srt_we     = 1'b0;
        srt_waddr  = p_reg[AW-1:0];
        srt_wdata  = v_reg;
        srt_re     = rd_en;
        srt_raddr  = rd_addr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = n;
                    i_next     = '0;
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                fill_we = 1'b1;
                if (last)
                begin
                    i_next     = '0;
                    state_next = S_CRD;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                end
            end
            S_CRD:
            begin
                key_re     = 1'b1;
                state_next = S_CMUL;
            end
            S_CMUL:
            begin
                prod_next  = PW'(n_reg) * PW'(key_q);
                state_next = S_CFRD;
            end
            S_CFRD:
            begin
                fill_re    = 1'b1;
                fill_raddr = bucket;
                b_next     = bucket;
                state_next = S_CFWR;
            end
            S_CFWR:
            begin
                fill_we    = 1'b1;
                fill_waddr = b_reg;
                fill_wdata = fill_q + CW'(1);
                if (last)
                begin
                    i_next     = '0;
                    start_next = '0;
                    state_next = S_PRD;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_CRD;
                end
            end
            S_PRD:
            begin
                fill_re    = 1'b1;
                state_next = S_PWR;
            end
            S_PWR:
            begin
                fill_we    = 1'b1;
                fill_wdata = start_reg;
                start_next = start_reg + fill_q;
                if (last)
                begin
                    i_next     = '0;
                    state_next = S_SRD;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_PRD;
                end
            end
            S_SRD:
            begin
                key_re     = 1'b1;
                state_next = S_SMUL;
            end
            S_SMUL:
            begin
                prod_next  = PW'(n_reg) * PW'(key_q);
                v_next     = key_q;
                state_next = S_SFRD;
            end
            S_SFRD:
            begin
                fill_re    = 1'b1;
                fill_raddr = bucket;
                b_next     = bucket;
                state_next = S_SFWR;
            end
            S_SFWR:
            begin
                fill_we    = 1'b1;
                fill_waddr = b_reg;
                fill_wdata = fill_q + CW'(1);
                srt_we     = 1'b1;
                srt_waddr  = fill_q[AW-1:0];
                srt_wdata  = v_reg;
                if (last)
                begin
                    i_next     = '0;
                    start_next = '0;
                    state_next = S_BRD;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_SRD;
                end
            end
            S_BRD:
            begin
                fill_re    = 1'b1;
                state_next = S_BGET;
            end
            S_BGET:
            begin
                end_next   = fill_q;
                j_next     = start_reg + CW'(1);
                state_next = S_JCHK;
            end
            S_JCHK:
            begin
                if (j_reg < end_reg)
                begin
                    srt_re     = 1'b1;
                    srt_raddr  = j_reg[AW-1:0];
                    state_next = S_JV;
                end
                else
                begin
                    start_next = end_reg;
                    if (last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = S_BRD;
                    end
                end
            end
            S_JV:
            begin
                v_next     = srt_q;
                p_next     = j_reg;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (p_reg > start_reg)
                begin
                    srt_re     = 1'b1;
                    srt_raddr  = p_dec[AW-1:0];
                    state_next = S_PCMP;
                end
                else
                begin
                    srt_we     = 1'b1;
                    j_next     = j_reg + CW'(1);
                    state_next = S_JCHK;
                end
            end
            S_PCMP:
            begin
                srt_we = 1'b1;
                if (srt_q > v_reg)
                begin
                    // shift the larger neighbor up one place
                    srt_wdata  = srt_q;
                    p_next     = p_dec;
                    state_next = S_PCHK;
                end
                else
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_JCHK;
                end
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        j_reg     <= j_next;
        p_reg     <= p_next;
        b_reg     <= b_next;
        v_reg     <= v_next;
        prod_reg  <= prod_next;
    end

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("sort started while busy");

    a_no_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en || ld_we) |-> !busy)
        else $error("store port used during sort");

    a_scatter_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SFWR) |-> (fill_q < n_reg))
        else $error("scatter position beyond set size");

endmodule

>>> rtl/bucket_sort_engine_core.sv
// A load is taken in T_IDLE; a read that finds data waits in T_RDW for the sorted store,
// while an empty read registers its result directly. The closing load starts the bse_sorter
// sequencer: clear, count, prefix and scatter passes, a bucket walk with an insertion sort
// per bucket, then done (n = set size); no item is accepted meanwhile.
// Reset (rst_n, async, low) empties the set, clears the overflow flag and out_valid.
// Top level of the bucket sort engine; depends on bse_pkg and bse_sorter.
module bucket_sort_engine_core #(
    parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [bse_pkg::KEY_BITS-1:0]    key,
    input  logic                            end_of_set,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bse_pkg::KEY_BITS-1:0]    sorted_key,
    output logic                            final_key,
    output logic [bse_pkg::STATUS_BITS-1:0] status
);
    import bse_pkg::*;

    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int AW = $clog2(MAX_ITEMS);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_SORT = 3'b010,
        T_RDW  = 3'b100
    } top_state_t;

    top_state_t           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        rp_reg, rp_next;
    logic                 ready_reg, ready_next;
    logic                 ovf_reg, ovf_next;
    logic                 fin_reg, fin_next;
    logic                 ov_reg, ov_next;
    logic [KEY_BITS-1:0]  okey_reg, okey_next;
    logic                 ofin_reg, ofin_next;
    logic [STATUS_BITS-1:0] ost_reg, ost_next;

    logic                 accept;
    logic [CW-1:0]        cnt_eff;
    logic                 sort_start, sort_busy, sort_done;
    logic                 ld_we, rd_en;
    logic [KEY_BITS-1:0]  rd_data;

    assign in_stall   = (state_reg != T_IDLE) || (ov_reg && out_stall);
    assign accept     = in_valid && !in_stall;
    assign cnt_eff    = ready_reg ? '0 : cnt_reg;
    assign out_valid  = ov_reg;
    assign sorted_key = okey_reg;
    assign final_key  = ofin_reg;
    assign status     = ost_reg;

    // Item handling
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rp_next    = rp_reg;
        ready_next = ready_reg;
        ovf_next   = ovf_reg;
        fin_next   = fin_reg;
        ov_next    = ov_reg && out_stall;
        okey_next  = okey_reg;
        ofin_next  = ofin_reg;
        ost_next   = ost_reg;
        sort_start = 1'b0;
        ld_we      = 1'b0;
        rd_en      = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept && op == OP_LOAD)
                begin
                    // a load after a sorted set opens a new one
                    if (ready_reg)
                    begin
                        rp_next    = '0;
                        ready_next = 1'b0;
                        ovf_next   = 1'b0;
                    end
                    if (cnt_eff < CW'(MAX_ITEMS))
                    begin
                        ld_we    = 1'b1;
                        cnt_next = cnt_eff + CW'(1);
                    end
                    else
                    begin
                        cnt_next = cnt_eff;
                        ovf_next = 1'b1;
                    end
                    if (end_of_set)
                    begin
                        sort_start = 1'b1;
                        state_next = T_SORT;
                    end
                end
                else if (accept)
                begin
                    if (!ready_reg || rp_reg >= cnt_reg)
                    begin
                        ov_next   = 1'b1;
                        okey_next = '0;
                        ofin_next = 1'b0;
                        ost_next  = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        fin_next   = (rp_reg + CW'(1) == cnt_reg);
                        rp_next    = rp_reg + CW'(1);
                        state_next = T_RDW;
                    end
                end
            end
            T_SORT:
            begin
                if (sort_done)
                begin
                    ready_next = 1'b1;
                    rp_next    = '0;
                    state_next = T_IDLE;
                end
            end
            T_RDW:
            begin
                ov_next    = 1'b1;
                okey_next  = rd_data;
                ofin_next  = fin_reg;
                ost_next   = ovf_reg ? ST_OVFL : ST_OK;
                state_next = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            cnt_reg   <= '0;
            rp_reg    <= '0;
            ready_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rp_reg    <= rp_next;
            ready_reg <= ready_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        fin_reg  <= fin_next;
        okey_reg <= okey_next;
        ofin_reg <= ofin_next;
        ost_reg  <= ost_next;
    end

    bse_sorter #(
        .MAX_ITEMS (MAX_ITEMS),
        .CW        (CW),
        .AW        (AW)
    ) u_sorter (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sort_start),
        .n       (cnt_next),
        .busy    (sort_busy),
        .done    (sort_done),
        .ld_we   (ld_we),
        .ld_addr (cnt_eff[AW-1:0]),
        .ld_key  (key),
        .rd_en   (rd_en),
        .rd_addr (rp_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    a_no_accept_sort: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !sort_busy)
        else $error("item accepted during sort");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= CW'(MAX_ITEMS)) && (rp_reg <= cnt_reg))
        else $error("count or read pointer out of range");

    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        sort_done |=> ready_reg && (rp_reg == '0))
        else $error("sort end not recorded");

endmodule

>>> tb/bucket_sort_engine_core_test.sv
// Self-checking testbench for bucket_sort_engine_core: loads key sets, reads them back sorted.
// Depends on bse_pkg and the bucket_sort_engine_core RTL.
`timescale 1ns / 100ps

module bucket_sort_engine_core_test;
    import bse_pkg::*;

    localparam int CAPACITY    = MAX_ITEMS_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [KEY_BITS-1:0]    sorted_key;
        logic                   final_key;
        logic [STATUS_BITS-1:0] status;
    } read_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   op;
    logic [KEY_BITS-1:0]    key;
    logic                   end_of_set;
    logic                   out_valid;
    logic                   out_stall;
    logic [KEY_BITS-1:0]    sorted_key;
    logic                   final_key;
    logic [STATUS_BITS-1:0] status;

    // Shadow state of the sorter
    logic [KEY_BITS-1:0] loaded_keys [CAPACITY];
    logic [KEY_BITS-1:0] sorted_keys [CAPACITY];
    int                  load_count;
    int                  read_index;
    logic                set_sorted;
    logic                set_overflow;

    read_result_t pending_reads[$];
    int           fail_count;
    int           items_sent;
    int           reads_sent;
    int           sets_sorted;
    int           cycle_count;
    int           idle_mode;
    int           stall_pct;
    int           stall_run;

    bucket_sort_engine_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .key        (key),
        .end_of_set (end_of_set),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sorted_key (sorted_key),
        .final_key  (final_key),
        .status     (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sort the closed set ascending; concatenated sorted buckets give the same order
    task automatic sort_loaded_set();
        logic [KEY_BITS-1:0] work[$];
        int                  n;
        n = (load_count > CAPACITY) ? CAPACITY : load_count;
        work.delete();
        for (int i = 0; i < n; i++)
            work = {work, loaded_keys[i]};
        work.sort();
        for (int i = 0; i < n; i++)
            sorted_keys[i] = work[i];
        sets_sorted++;
    endtask

    // Advance the shadow state by one accepted item
    task automatic predict_item(input logic i_op, input logic [KEY_BITS-1:0] i_key,
                                input logic i_eos);
        read_result_t r;
        if (i_op == OP_LOAD)
        begin
            if (set_sorted)
            begin
                load_count   = 0;
                read_index   = 0;
                set_sorted   = 1'b0;
                set_overflow = 1'b0;
            end
            if (load_count < CAPACITY)
            begin
                loaded_keys[load_count] = i_key;
                load_count++;
            end
            else
                set_overflow = 1'b1;
            if (i_eos)
            begin
                sort_loaded_set();
                read_index = 0;
                set_sorted = 1'b1;
            end
        end
        else
        begin
            if (!set_sorted || read_index >= load_count || read_index >= CAPACITY)
            begin
                r.sorted_key = '0;
                r.final_key  = 1'b0;
                r.status     = ST_EMPTY;
            end
            else
            begin
                r.sorted_key = sorted_keys[read_index];
                r.final_key  = (read_index + 1 == load_count);
                r.status     = set_overflow ? ST_OVFL : ST_OK;
                read_index++;
            end
            pending_reads = {pending_reads, r};
        end
    endtask

    // Pick an idle gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (idle_mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Drive one item and hold it until accepted; called at a rising edge
    task automatic send_item(input logic i_op, input logic [KEY_BITS-1:0] i_key,
                             input logic i_eos);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op         <= i_op;
        key        <= i_key;
        end_of_set <= i_eos;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item(i_op, i_key, i_eos);
        items_sent++;
        if (i_op == OP_READ)
            reads_sent++;
    endtask

    task automatic load_key(input logic [KEY_BITS-1:0] k, input logic eos);
        send_item(OP_LOAD, k, eos);
    endtask

    // Reads carry random key and end flag bits, which the block ignores
    task automatic read_key();
        send_item(OP_READ, KEY_BITS'($urandom), 1'($urandom));
    endtask

    // Stall the result side in runs of random length
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end
        else if (stall_run > 0)
            stall_run <= stall_run - 1;
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
            stall_run <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reads.size() == 0)
            begin
                $error("unexpected result: sorted_key %0h", sorted_key);
                fail_count++;
            end
            else
            begin
                if (sorted_key !== pending_reads[0].sorted_key)
                begin
                    $error("sorted_key: expected %0h, got %0h",
                           pending_reads[0].sorted_key, sorted_key);
                    fail_count++;
                end
                if (final_key !== pending_reads[0].final_key)
                begin
                    $error("final_key: expected %0b, got %0b",
                           pending_reads[0].final_key, final_key);
                    fail_count++;
                end
                if (status !== pending_reads[0].status)
                begin
                    $error("status: expected %0d, got %0d",
                           pending_reads[0].status, status);
                    fail_count++;
                end
                void'(pending_reads.pop_front());
            end
        end
    end

    // Reads with no sorted set, and a read before any set closes
    task automatic test_empty_reads();
        read_key();
        read_key();
        load_key(16'h1234, 1'b0);
        read_key();
        load_key(16'h0042, 1'b1);
        read_key();
        read_key();
        read_key();
        read_key();
    endtask

    // Extreme keys, duplicates, a one-key set
    task automatic test_extremes();
        load_key(16'hFFFF, 1'b0);
        load_key(16'h0000, 1'b0);
        load_key(16'h8000, 1'b0);
        load_key(16'hFFFF, 1'b0);
        load_key(16'h0000, 1'b0);
        load_key(16'h7FFF, 1'b1);
        repeat (7) read_key();
        load_key(16'hFFFF, 1'b1);
        repeat (2) read_key();
    endtask

    // Loads in the middle of a readout start a new set
    task automatic test_restart();
        load_key(16'h0300, 1'b0);
        load_key(16'h0200, 1'b0);
        load_key(16'h0100, 1'b1);
        read_key();
        load_key(16'hAAAA, 1'b0);
        load_key(16'h5555, 1'b1);
        repeat (3) read_key();
    endtask

    // Random sets, mostly well formed, with noise reads and early restarts
    task automatic test_random(input int target);
        int                  n;
        int                  reads;
        logic [KEY_BITS-1:0] pool[4];
        logic                clustered;
        while (items_sent < target)
        begin
            idle_mode = ($urandom_range(0, 3) != 0);
            stall_pct = $urandom_range(0, 60);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
            clustered = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 4; i++)
                pool[i] = KEY_BITS'($urandom);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                    read_key();
                load_key(clustered ? pool[$urandom_range(0, 3)] : KEY_BITS'($urandom),
                         i == n - 1);
            end
            case ($urandom_range(0, 3))
                0:       reads = $urandom_range(0, n);
                1:       reads = n + $urandom_range(1, 3);
                default: reads = n;
            endcase
            repeat (reads) read_key();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_LOAD;
        key          = '0;
        end_of_set   = 1'b0;
        load_count   = 0;
        read_index   = 0;
        set_sorted   = 1'b0;
        set_overflow = 1'b0;
        fail_count   = 0;
        items_sent   = 0;
        reads_sent   = 0;
        sets_sorted  = 0;
        cycle_count  = 0;
        idle_mode    = 1;
        stall_pct    = 20;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_reads();
        test_extremes();
        test_restart();
        test_random(450);

        in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Covered %0d items (%0d reads) over %0d sorted sets,", items_sent, reads_sent,
                 sets_sorted);
        $display("including empty reads, duplicate keys and restarts mid-readout.");
        if (fail_count == 0 && pending_reads.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> bucket_sort_engine_core.f
rtl/bse_pkg.sv
rtl/bse_sorter.sv
rtl/bucket_sort_engine_core.sv
tb/bucket_sort_engine_core_test.sv
